// ----- sv/vrbr_pkg.sv -----
// Shared types, constants and helper functions of the view range budget regulator.
`default_nettype none

package vrbr_pkg;

  localparam int unsigned DistW   = 16;
  localparam int unsigned TimeW   = 20;
  localparam int unsigned RateW   = 16;
  localparam int unsigned LimW    = 48;
  localparam int unsigned CoefW   = 14;
  localparam int unsigned MrW     = 30;
  localparam int unsigned QuotW   = 17;
  localparam int unsigned RemW    = 14;
  localparam int unsigned CntW    = 5;
  localparam int unsigned Regions = 3;

  localparam logic [CoefW-1:0] LoopUs    = CoefW'(16000);
  localparam logic [MrW-1:0]   RoundHalf = MrW'(8000);
  localparam logic [5:0]       GapBack   = 6'd16;
  localparam logic [5:0]       GapFront  = 6'd32;

  localparam logic [CntW-1:0] MulSteps  = CntW'(16);
  localparam logic [CntW-1:0] DivSteps  = CntW'(17);
  localparam logic [CntW-1:0] ContSteps = CntW'(4);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COEF,
    S_MUL,
    S_PREP,
    S_DIV,
    S_WB,
    S_CONT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_BUDGET    = 3'd1,
    REG_STEP_DOWN = 3'd2,
    REG_STEP_UP   = 3'd3,
    REG_MIN_BACK  = 3'd4,
    REG_MIN_FRONT = 3'd5,
    REG_MAX_BACK  = 3'd6,
    REG_MAX_FRONT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic coef_step;
    logic mul_step;
    logic div_prep;
    logic div_step;
    logic wb;
  } ctrl_t;

  // One containment step: cap below the outer neighbor or raise above the
  // inner one, then clamp to the region limits (maximum wins when crossed).
  function automatic logic [DistW-1:0] contain_step(
    input logic [DistW-1:0] x,
    input logic [DistW-1:0] nbr,
    input logic [5:0]       gap,
    input logic             inward,
    input logic [DistW-1:0] lo,
    input logic [DistW-1:0] hi
  );
    logic [DistW-1:0] bound;
    logic [DistW:0]   wide;
    logic [DistW-1:0] y;
    wide = {1'b0, nbr} + {{(DistW-5){1'b0}}, gap};
    if (inward) begin
      bound = (nbr > {{(DistW-6){1'b0}}, gap}) ? nbr - {{(DistW-6){1'b0}}, gap} : '0;
      y = (x < bound) ? x : bound;
    end else begin
      bound = wide[DistW] ? {DistW{1'b1}} : wide[DistW-1:0];
      y = (x > bound) ? x : bound;
    end
    if (y < lo) y = lo;
    if (y > hi) y = hi;
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- sv/view_range_budget_regulator.sv -----
// Top level of the view range budget regulator: registers, sequencer and containment.
//
// Each accepted request carries the near and far workload times of one frame.
// With regulation on, all six distances are scaled in parallel by bit-serial
// units: they form the clamped coefficient times the selected rate, multiply
// it by the distance, round, divide by the 16 ms loop time, write back and
// run the containment steps (one region per cycle for back and front
// together). A request holds the block from its acceptance until its result
// is loaded into the output register; with regulation off it goes straight
// to the done state. The result sits in an output register, so the block
// accepts the next request while the previous result still waits.
// Configuration goes through an APB-style port with 64-bit data; register i
// lies at byte address 8*i and writes are meant to happen only while the
// block is idle. After reset all distances are zero.
`default_nettype none

module view_range_budget_regulator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [19:0]  near_time_us_i,
  input  wire logic [19:0]  far_time_us_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [15:0]       region1_back_o,
  output logic [15:0]       region1_front_o,
  output logic [15:0]       region2_back_o,
  output logic [15:0]       region2_front_o,
  output logic [15:0]       region3_back_o,
  output logic [15:0]       region3_front_o,
  output logic              was_regulated_o
);

  localparam int unsigned DW = vrbr_pkg::DistW;

  // Configuration registers.
  logic                        enable_q;
  logic [vrbr_pkg::TimeW-1:0]  budget_q;
  logic [vrbr_pkg::RateW-1:0]  step_down_q, step_up_q;
  logic [vrbr_pkg::LimW-1:0]   min_back_q, min_front_q, max_back_q, max_front_q;
  logic                        cfg_write;
  vrbr_pkg::reg_idx_e          reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = vrbr_pkg::reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      budget_q    <= vrbr_pkg::TimeW'(2000);
      step_down_q <= vrbr_pkg::RateW'(3277);
      step_up_q   <= vrbr_pkg::RateW'(3277);
      min_back_q  <= '0;
      min_front_q <= '0;
      max_back_q  <= '1;
      max_front_q <= '1;
    end else if (cfg_write) begin
      unique case (reg_idx)
        vrbr_pkg::REG_ENABLE:    enable_q    <= pwdata[0];
        vrbr_pkg::REG_BUDGET:    budget_q    <= pwdata[vrbr_pkg::TimeW-1:0];
        vrbr_pkg::REG_STEP_DOWN: step_down_q <= pwdata[vrbr_pkg::RateW-1:0];
        vrbr_pkg::REG_STEP_UP:   step_up_q   <= pwdata[vrbr_pkg::RateW-1:0];
        vrbr_pkg::REG_MIN_BACK:  min_back_q  <= pwdata[vrbr_pkg::LimW-1:0];
        vrbr_pkg::REG_MIN_FRONT: min_front_q <= pwdata[vrbr_pkg::LimW-1:0];
        vrbr_pkg::REG_MAX_BACK:  max_back_q  <= pwdata[vrbr_pkg::LimW-1:0];
        vrbr_pkg::REG_MAX_FRONT: max_front_q <= pwdata[vrbr_pkg::LimW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      vrbr_pkg::REG_ENABLE:    prdata = {63'b0, enable_q};
      vrbr_pkg::REG_BUDGET:    prdata = {44'b0, budget_q};
      vrbr_pkg::REG_STEP_DOWN: prdata = {48'b0, step_down_q};
      vrbr_pkg::REG_STEP_UP:   prdata = {48'b0, step_up_q};
      vrbr_pkg::REG_MIN_BACK:  prdata = {16'b0, min_back_q};
      vrbr_pkg::REG_MIN_FRONT: prdata = {16'b0, min_front_q};
      vrbr_pkg::REG_MAX_BACK:  prdata = {16'b0, max_back_q};
      vrbr_pkg::REG_MAX_FRONT: prdata = {16'b0, max_front_q};
    endcase
  end

  // Sequencer.
  vrbr_pkg::state_e           state_q, state_d;
  logic [vrbr_pkg::CntW-1:0]  cnt_q, cnt_d;
  vrbr_pkg::ctrl_t            ctrl;
  logic                       in_acc, out_load;
  logic                       regulated_q;
  logic [2:0][DW-1:0]         back_q, back_d, front_q, front_d;
  logic [2:0][DW-1:0]         back_res, front_res;

  assign in_stall_o = state_q != vrbr_pkg::S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vrbr_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q + 1'b1;
    ctrl     = '0;
    out_load = 1'b0;
    unique case (state_q)
      vrbr_pkg::S_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          ctrl.load = 1'b1;
          state_d   = enable_q ? vrbr_pkg::S_COEF : vrbr_pkg::S_DONE;
        end
      end
      vrbr_pkg::S_COEF: begin
        ctrl.coef_step = 1'b1;
        if (cnt_q == vrbr_pkg::MulSteps - 1'b1) begin
          cnt_d   = '0;
          state_d = vrbr_pkg::S_MUL;
        end
      end
      vrbr_pkg::S_MUL: begin
        ctrl.mul_step = 1'b1;
        if (cnt_q == vrbr_pkg::MulSteps - 1'b1) begin
          state_d = vrbr_pkg::S_PREP;
        end
      end
      vrbr_pkg::S_PREP: begin
        ctrl.div_prep = 1'b1;
        cnt_d         = '0;
        state_d       = vrbr_pkg::S_DIV;
      end
      vrbr_pkg::S_DIV: begin
        ctrl.div_step = 1'b1;
        if (cnt_q == vrbr_pkg::DivSteps - 1'b1) begin
          state_d = vrbr_pkg::S_WB;
        end
      end
      vrbr_pkg::S_WB: begin
        ctrl.wb = 1'b1;
        cnt_d   = '0;
        state_d = vrbr_pkg::S_CONT;
      end
      vrbr_pkg::S_CONT: begin
        if (cnt_q == vrbr_pkg::ContSteps - 1'b1) begin
          state_d = vrbr_pkg::S_DONE;
        end
      end
      vrbr_pkg::S_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = vrbr_pkg::S_IDLE;
        end
      end
      default: state_d = vrbr_pkg::S_IDLE;
    endcase
  end

  // Coefficient units: the near time drives regions one and two, the far
  // time drives region three.
  logic                       over_near, over_far;
  logic [vrbr_pkg::MrW-1:0]   mr_near, mr_far;

  vrbr_coef u_coef_near (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .budget_i    (budget_q),
    .measured_i  (near_time_us_i),
    .rate_down_i (step_down_q),
    .rate_up_i   (step_up_q),
    .over_o      (over_near),
    .mr_o        (mr_near)
  );

  vrbr_coef u_coef_far (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .budget_i    (budget_q),
    .measured_i  (far_time_us_i),
    .rate_down_i (step_down_q),
    .rate_up_i   (step_up_q),
    .over_o      (over_far),
    .mr_o        (mr_far)
  );

  for (genvar g = 0; g < vrbr_pkg::Regions; g++) begin : g_lane
    logic                     over;
    logic [vrbr_pkg::MrW-1:0] mr;
    if (g < 2) begin : g_near
      assign over = over_near;
      assign mr   = mr_near;
    end else begin : g_far
      assign over = over_far;
      assign mr   = mr_far;
    end

    vrbr_scale u_back (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .dist_i (back_q[g]),
      .over_i (over),
      .mr_i   (mr),
      .res_o  (back_res[g])
    );

    vrbr_scale u_front (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .dist_i (front_q[g]),
      .over_i (over),
      .mr_i   (mr),
      .res_o  (front_res[g])
    );
  end

  // Containment: steps zero and one go from the outside in (regions two then
  // one), steps two and three from the inside out (regions two then three).
  always_comb begin
    back_d  = back_q;
    front_d = front_q;
    if (ctrl.wb) begin
      back_d  = back_res;
      front_d = front_res;
    end else if (state_q == vrbr_pkg::S_CONT) begin
      case (cnt_q[1:0])
        2'd0: begin
          back_d[1]  = vrbr_pkg::contain_step(back_q[1], back_q[2], vrbr_pkg::GapBack,
                         1'b1, min_back_q[DW +: DW], max_back_q[DW +: DW]);
          front_d[1] = vrbr_pkg::contain_step(front_q[1], front_q[2], vrbr_pkg::GapFront,
                         1'b1, min_front_q[DW +: DW], max_front_q[DW +: DW]);
        end
        2'd1: begin
          back_d[0]  = vrbr_pkg::contain_step(back_q[0], back_q[1], vrbr_pkg::GapBack,
                         1'b1, min_back_q[0 +: DW], max_back_q[0 +: DW]);
          front_d[0] = vrbr_pkg::contain_step(front_q[0], front_q[1], vrbr_pkg::GapFront,
                         1'b1, min_front_q[0 +: DW], max_front_q[0 +: DW]);
        end
        2'd2: begin
          back_d[1]  = vrbr_pkg::contain_step(back_q[1], back_q[0], vrbr_pkg::GapBack,
                         1'b0, min_back_q[DW +: DW], max_back_q[DW +: DW]);
          front_d[1] = vrbr_pkg::contain_step(front_q[1], front_q[0], vrbr_pkg::GapFront,
                         1'b0, min_front_q[DW +: DW], max_front_q[DW +: DW]);
        end
        default: begin
          back_d[2]  = vrbr_pkg::contain_step(back_q[2], back_q[1], vrbr_pkg::GapBack,
                         1'b0, min_back_q[2*DW +: DW], max_back_q[2*DW +: DW]);
          front_d[2] = vrbr_pkg::contain_step(front_q[2], front_q[1], vrbr_pkg::GapFront,
                         1'b0, min_front_q[2*DW +: DW], max_front_q[2*DW +: DW]);
        end
      endcase
    end
  end

  // Stored distances start at the reset minimum limits, which are zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_q      <= '0;
      front_q     <= '0;
      regulated_q <= 1'b0;
    end else begin
      back_q  <= back_d;
      front_q <= front_d;
      if (in_acc) begin
        regulated_q <= enable_q;
      end
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      region1_back_o  <= back_q[0];
      region1_front_o <= front_q[0];
      region2_back_o  <= back_q[1];
      region2_front_o <= front_q[1];
      region3_back_o  <= back_q[2];
      region3_front_o <= front_q[2];
      was_regulated_o <= regulated_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_held_when_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !enable_q) |=> ($stable(back_q) && $stable(front_q)))
    else $error("distances changed on a held request");

  a_accept_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == vrbr_pkg::S_COEF || state_q == vrbr_pkg::S_DONE))
    else $error("accepted request did not start regulation or finish");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q) == vrbr_pkg::S_DONE)
    else $error("result appeared outside the done state");

endmodule

`default_nettype wire

// ----- sv/vrbr_coef.sv -----
// Budget error, clamped coefficient and serial coefficient-times-rate product.
`default_nettype none

module vrbr_coef (
  input  wire logic                        clk_i,
  input  wire vrbr_pkg::ctrl_t             ctrl_i,
  input  wire logic [vrbr_pkg::TimeW-1:0]  budget_i,
  input  wire logic [vrbr_pkg::TimeW-1:0]  measured_i,
  input  wire logic [vrbr_pkg::RateW-1:0]  rate_down_i,
  input  wire logic [vrbr_pkg::RateW-1:0]  rate_up_i,
  output logic                             over_o,
  output logic [vrbr_pkg::MrW-1:0]         mr_o
);

  logic                          over_d, over_q;
  logic [vrbr_pkg::TimeW-1:0]    err_abs;
  logic [vrbr_pkg::CoefW-1:0]    m_d, m_q;
  logic [vrbr_pkg::RateW-1:0]    r_d, r_q;
  logic [vrbr_pkg::MrW-1:0]      acc_d, acc_q;

  always_comb begin
    over_d  = measured_i > budget_i;
    err_abs = over_d ? measured_i - budget_i : budget_i - measured_i;
    m_d     = (err_abs > {{(vrbr_pkg::TimeW-vrbr_pkg::CoefW){1'b0}}, vrbr_pkg::LoopUs})
              ? vrbr_pkg::LoopUs : err_abs[vrbr_pkg::CoefW-1:0];
    r_d     = over_d ? rate_down_i : rate_up_i;
    acc_d   = {acc_q[vrbr_pkg::MrW-2:0], 1'b0}
              + (r_q[vrbr_pkg::RateW-1]
                 ? {{(vrbr_pkg::MrW-vrbr_pkg::CoefW){1'b0}}, m_q} : '0);
  end

  // Rate bits are taken most significant first, one per cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      over_q <= over_d;
      m_q    <= m_d;
      r_q    <= r_d;
      acc_q  <= '0;
    end else if (ctrl_i.coef_step) begin
      r_q   <= {r_q[vrbr_pkg::RateW-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign over_o = over_q;
  assign mr_o   = acc_q;

endmodule

`default_nettype wire

// ----- sv/vrbr_scale.sv -----
// Serial distance multiply, rounding and divide by the loop time for one distance.
`default_nettype none

module vrbr_scale (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vrbr_pkg::ctrl_t             ctrl_i,
  input  wire logic [vrbr_pkg::DistW-1:0]  dist_i,
  input  wire logic                        over_i,
  input  wire logic [vrbr_pkg::MrW-1:0]    mr_i,
  output logic [vrbr_pkg::DistW-1:0]       res_o
);

  logic [vrbr_pkg::DistW-1:0] d_q, ds_q;
  logic [vrbr_pkg::MrW-1:0]   acc_q;
  logic [vrbr_pkg::MrW:0]     mul_sum;
  logic [vrbr_pkg::MrW-1:0]   rounded;
  logic [vrbr_pkg::RemW-1:0]  rem_q;
  logic [vrbr_pkg::RemW:0]    trial;
  logic                       fits;
  logic [vrbr_pkg::QuotW-1:0] dl_q;
  logic [vrbr_pkg::QuotW:0]   up_sum;

  always_comb begin
    // Shift-right accumulation keeps only the product divided by 2^16.
    mul_sum = {1'b0, acc_q} + (ds_q[0] ? {1'b0, mr_i} : '0);
    rounded = acc_q + vrbr_pkg::RoundHalf;
    trial   = {rem_q, dl_q[vrbr_pkg::QuotW-1]};
    fits    = trial >= {1'b0, vrbr_pkg::LoopUs};
    up_sum  = {2'b0, d_q} + {1'b0, dl_q};
    if (over_i) begin
      res_o = d_q - dl_q[vrbr_pkg::DistW-1:0];
    end else if (up_sum > {2'b0, {vrbr_pkg::DistW{1'b1}}}) begin
      res_o = {vrbr_pkg::DistW{1'b1}};
    end else begin
      res_o = up_sum[vrbr_pkg::DistW-1:0];
    end
  end

  // The low dividend bits and the quotient share one shift register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      d_q   <= dist_i;
      ds_q  <= dist_i;
      acc_q <= '0;
    end else if (ctrl_i.mul_step) begin
      ds_q  <= {1'b0, ds_q[vrbr_pkg::DistW-1:1]};
      acc_q <= mul_sum[vrbr_pkg::MrW:1];
    end else if (ctrl_i.div_prep) begin
      rem_q <= {1'b0, rounded[vrbr_pkg::MrW-1:vrbr_pkg::QuotW]};
      dl_q  <= rounded[vrbr_pkg::QuotW-1:0];
    end else if (ctrl_i.div_step) begin
      rem_q <= fits ? vrbr_pkg::RemW'(trial - {1'b0, vrbr_pkg::LoopUs})
                    : trial[vrbr_pkg::RemW-1:0];
      dl_q  <= {dl_q[vrbr_pkg::QuotW-2:0], fits};
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_step |-> rem_q < vrbr_pkg::LoopUs)
    else $error("divider remainder reached the divisor");

  a_shrink_within_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wb && over_i) |-> dl_q <= {1'b0, d_q})
    else $error("shrink step larger than the distance");

endmodule

`default_nettype wire
